@@ sv/bunch_event_fragment_matcher_assert.svh @@
// Assertion macros for the bunch event fragment matcher.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef BUNCH_EVENT_FRAGMENT_MATCHER_ASSERT_SVH
`define BUNCH_EVENT_FRAGMENT_MATCHER_ASSERT_SVH

`ifndef SYNTHESIS
`define BEFM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BEFM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BEFM_ASSERT(lbl, clk, rst_n, prop, msg)
`define BEFM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ sv/befm_pkg.sv @@
// Package for the bunch event fragment matcher: types, codes, constants
// and the receiver to chip map. No dependencies.
`timescale 1ns / 1ps

package befm_pkg;

    localparam int BUNCH_W = 9;
    localparam int CHIP_W  = 4;
    localparam int TRIG_W  = 32;
    localparam int CNT_W   = 5;
    localparam int RECV_W  = 4;
    localparam int ENA_W   = 4;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 32;

    localparam logic [BUNCH_W-1:0] FAIL_BUNCH = 9'd256;
    localparam logic [BUNCH_W-1:0] NONE_BUNCH = 9'd257;
    localparam logic [CNT_W-1:0]   CNT_MAX    = '1;
    localparam logic [TRIG_W-1:0]  TRIG_MAX   = '1;

    localparam logic [ENA_W-1:0]  ENABLED_RST = 4'd9;
    localparam logic [TRIG_W-1:0] TARGET_RST  = 32'd1000000000;

    localparam int MAP_DEPTH = 9;
    localparam logic [CHIP_W-1:0] RCV_TO_CHIP [MAP_DEPTH] =
        '{4'd8, 4'd7, 4'd6, 4'd0, 4'd5, 4'd1, 4'd4, 4'd2, 4'd3};

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_RECV = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        RK_HITS  = 2'd0,
        RK_EMPTY = 2'd1,
        RK_ERROR = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLED = 4'd0,
        CFG_TARGET  = 4'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CALC
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [TRIG_W-1:0] trigger;
    } t_pay;

    typedef struct packed {
        logic found;
        logic full;
    } t_srch;

    typedef struct packed {
        logic open;
        logic close;
        logic update;
    } t_slot_cmd;

    function automatic logic [CHIP_W-1:0] chip_of(input logic [RECV_W-1:0] idx);
        logic [CHIP_W-1:0] chip;
        if (idx < RECV_W'(MAP_DEPTH)) begin
            chip = RCV_TO_CHIP[idx];
        end else begin
            chip = idx;
        end
        return chip;
    endfunction

endpackage

@@ sv/befm_if.sv @@
// Channel interfaces: fragment input, result output, configuration writes.
// Depends on befm_pkg for field widths.
`timescale 1ns / 1ps

interface befm_in_if;
    logic                           valid;
    logic                           ready;
    logic [befm_pkg::RECV_W-1:0]    receiver;
    logic [7:0]                     bunch_value;
    logic                           decode_ok;
    logic                           has_hits;
    logic                           hits_consistent;

    modport source (output valid, receiver, bunch_value, decode_ok, has_hits,
                    hits_consistent, input ready);
    modport sink (input valid, receiver, bunch_value, decode_ok, has_hits,
                  hits_consistent, output ready);
endinterface

interface befm_out_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     status;
    logic [befm_pkg::CHIP_W-1:0]    chip_id;
    logic [befm_pkg::TRIG_W-1:0]    trigger_number;
    logic [1:0]                     record_kind;
    logic [befm_pkg::BUNCH_W-1:0]   bunch_out;
    logic                           opened;
    logic                           closed;
    logic                           repeated;
    logic                           several_open;
    logic                           run_done;

    modport source (output valid, status, chip_id, trigger_number, record_kind,
                    bunch_out, opened, closed, repeated, several_open, run_done,
                    input ready);
    modport sink (input valid, status, chip_id, trigger_number, record_kind,
                  bunch_out, opened, closed, repeated, several_open, run_done,
                  output ready);
endinterface

interface befm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [befm_pkg::CFG_IDX_W-1:0] index;
    logic [befm_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ sv/befm_slot_table.sv @@
// Open bunch table: bunch tags and valid bits in flops for a parallel
// search, count and trigger per slot in a registered-read memory.
// Depends on befm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "bunch_event_fragment_matcher_assert.svh"

module befm_slot_table #(
    parameter int OPEN_SLOTS = 8,
    parameter int SW = $clog2(OPEN_SLOTS),
    parameter int TW = $clog2(OPEN_SLOTS + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [befm_pkg::BUNCH_W-1:0]   i_bunch,
    output befm_pkg::t_srch                o_srch,
    output logic [SW-1:0]                  o_slot,
    output logic [TW-1:0]                  o_total,
    input  logic [SW-1:0]                  i_rd_slot,
    output befm_pkg::t_pay                 o_rd,
    input  befm_pkg::t_slot_cmd            i_cmd,
    input  logic [SW-1:0]                  i_wr_slot,
    input  logic [befm_pkg::BUNCH_W-1:0]   i_wr_bunch,
    input  befm_pkg::t_pay                 i_wr_pay
);

    logic [befm_pkg::BUNCH_W-1:0] r_tag [OPEN_SLOTS];
    logic [OPEN_SLOTS-1:0]        r_vld;
    befm_pkg::t_pay               r_mem [OPEN_SLOTS];
    befm_pkg::t_pay               r_rd;
    logic [TW-1:0]                r_total;

    logic [OPEN_SLOTS-1:0]        w_hit;
    logic [SW-1:0]                w_hit_idx;
    logic [SW-1:0]                w_free_idx;

    always_comb begin
        for (int i = 0; i < OPEN_SLOTS; i++) begin
            w_hit[i] = r_vld[i] && (r_tag[i] == i_bunch);
        end
    end

    always_comb begin
        w_hit_idx  = '0;
        w_free_idx = '0;
        for (int i = OPEN_SLOTS - 1; i >= 0; i--) begin
            if (w_hit[i]) begin
                w_hit_idx = SW'(i);
            end
            if (!r_vld[i]) begin
                w_free_idx = SW'(i);
            end
        end
    end

    assign o_srch.found = |w_hit;
    assign o_srch.full  = &r_vld;
    assign o_slot       = o_srch.found ? w_hit_idx : w_free_idx;
    assign o_total      = r_total;
    assign o_rd         = r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_total <= '0;
        end else begin
            if (i_cmd.open) begin
                r_vld[i_wr_slot] <= 1'b1;
                r_total          <= r_total + TW'(1);
            end else if (i_cmd.close) begin
                r_vld[i_wr_slot] <= 1'b0;
                r_total          <= r_total - TW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.open) begin
            r_tag[i_wr_slot] <= i_wr_bunch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.open || i_cmd.update) begin
            r_mem[i_wr_slot] <= i_wr_pay;
        end
        r_rd <= r_mem[i_rd_slot];
    end

    `BEFM_ASSERT(a_total_tracks_vld, i_clk, i_rst_n, int'(r_total) == $countones(r_vld), "open count differs from valid slots")
    `BEFM_ASSERT(a_tag_unique, i_clk, i_rst_n, $onehot0(w_hit), "bunch matches more than one slot")
    `BEFM_ASSERT(a_open_free, i_clk, i_rst_n, i_cmd.open |-> !r_vld[i_wr_slot], "open into occupied slot")
    `BEFM_ASSERT(a_touch_valid, i_clk, i_rst_n, (i_cmd.close || i_cmd.update) |-> r_vld[i_wr_slot], "update of empty slot")

endmodule

@@ sv/befm_chip_hist.sv @@
// Last bunch seen per chip: registered-read memory with per-entry valid
// flops; an entry never written reads as the none marker. Depends on befm_pkg.
`timescale 1ns / 1ps

module befm_chip_hist #(
    parameter int CHIP_COUNT = 9,
    parameter int CW = (CHIP_COUNT > 1) ? $clog2(CHIP_COUNT) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [CW-1:0]                  i_rd_idx,
    output logic [befm_pkg::BUNCH_W-1:0]   o_last,
    input  logic                           i_wr_en,
    input  logic [CW-1:0]                  i_wr_idx,
    input  logic [befm_pkg::BUNCH_W-1:0]   i_wr_bunch
);

    logic [befm_pkg::BUNCH_W-1:0] r_mem [CHIP_COUNT];
    logic [CHIP_COUNT-1:0]        r_vld;
    logic [befm_pkg::BUNCH_W-1:0] r_q;
    logic                         r_qv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_qv  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_idx] <= 1'b1;
            end
            r_qv <= r_vld[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_bunch;
        end
        r_q <= r_mem[i_rd_idx];
    end

    assign o_last = r_qv ? r_q : befm_pkg::NONE_BUNCH;

endmodule

@@ sv/bunch_event_fragment_matcher.sv @@
// A fragment passes search, memory read and update; a stalled result holds the update.
// A new fragment is taken only once the last one has been written back, since the
// slot memory and the per-chip history memory are read, modified and written.
// Reset (i_rst_n low, synchronous): valid bits of both tables and all counters clear
// at once, no clearing pass; enabled_count returns to 9, trigger_target to 1e9.
// Depends on befm_pkg, befm_if, befm_slot_table, befm_chip_hist, assertion macros.
`timescale 1ns / 1ps
`include "bunch_event_fragment_matcher_assert.svh"

module bunch_event_fragment_matcher #(
    parameter int OPEN_SLOTS = 8,
    parameter int CHIP_COUNT = 9
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    befm_in_if.sink    i_in,
    befm_out_if.source o_out,
    befm_cfg_if.sink   i_cfg
);

    localparam int SW = $clog2(OPEN_SLOTS);
    localparam int TW = $clog2(OPEN_SLOTS + 1);
    localparam int CW = (CHIP_COUNT > 1) ? $clog2(CHIP_COUNT) : 1;
    localparam int BW = befm_pkg::BUNCH_W;
    localparam int RW = befm_pkg::RECV_W;
    localparam int XW = befm_pkg::TRIG_W;

    befm_pkg::t_state r_state, n_state;

    logic [befm_pkg::ENA_W-1:0]   r_enabled;
    logic [XW-1:0]                r_target;
    logic [XW-1:0]                r_opened_cnt;
    logic [XW-1:0]                r_closed_cnt;

    logic                         r_recv_ok;
    logic [CW-1:0]                r_idx;
    logic [befm_pkg::CHIP_W-1:0]  r_chip;
    logic [BW-1:0]                r_bunch;
    befm_pkg::t_kind              r_kind;
    befm_pkg::t_srch              r_srch;
    logic [SW-1:0]                r_slot;

    logic                         r_out_valid;
    befm_pkg::t_status            r_o_status;
    logic [befm_pkg::CHIP_W-1:0]  r_o_chip;
    logic [XW-1:0]                r_o_trig;
    befm_pkg::t_kind              r_o_kind;
    logic [BW-1:0]                r_o_bunch;
    logic                         r_o_opened;
    logic                         r_o_closed;
    logic                         r_o_rep;
    logic                         r_o_several;
    logic                         r_o_done;

    logic                         w_in_ready;
    logic                         w_accept;
    logic                         w_commit;
    logic                         w_out_free;

    logic                         w_recv_ok;
    logic [RW-1:0]                w_idx;
    logic [BW-1:0]                w_bunch;
    befm_pkg::t_kind              w_kind;
    befm_pkg::t_srch              w_srch;
    logic [SW-1:0]                w_slot;
    logic [TW-1:0]                w_total;

    befm_pkg::t_pay               w_rd;
    logic [BW-1:0]                w_last;
    logic [befm_pkg::CNT_W-1:0]   w_cnt_inc;
    logic                         w_do_step;
    logic                         w_do_open;
    logic                         w_do_close;
    logic                         w_do_update;
    logic                         w_rep;
    befm_pkg::t_status            w_status;
    logic [XW-1:0]                w_trig;
    logic [TW-1:0]                n_total;
    logic [XW-1:0]                n_closed_cnt;
    befm_pkg::t_slot_cmd          w_cmd;
    befm_pkg::t_pay               w_wr_pay;

    // input side
    assign w_accept  = i_in.valid && w_in_ready;
    assign i_in.ready = w_in_ready;
    assign w_recv_ok = (i_in.receiver != '0) &&
                       ({1'b0, i_in.receiver} <= (RW + 1)'(CHIP_COUNT));
    assign w_idx     = i_in.receiver - RW'(1);
    assign w_bunch   = i_in.decode_ok ? {1'b0, i_in.bunch_value} : befm_pkg::FAIL_BUNCH;

    always_comb begin
        if (!i_in.decode_ok || (i_in.has_hits && !i_in.hits_consistent)) begin
            w_kind = befm_pkg::RK_ERROR;
        end else if (i_in.has_hits) begin
            w_kind = befm_pkg::RK_HITS;
        end else begin
            w_kind = befm_pkg::RK_EMPTY;
        end
    end

    befm_slot_table #(
        .OPEN_SLOTS (OPEN_SLOTS),
        .SW         (SW),
        .TW         (TW)
    ) u_slot_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_bunch    (w_bunch),
        .o_srch     (w_srch),
        .o_slot     (w_slot),
        .o_total    (w_total),
        .i_rd_slot  (r_slot),
        .o_rd       (w_rd),
        .i_cmd      (w_cmd),
        .i_wr_slot  (r_slot),
        .i_wr_bunch (r_bunch),
        .i_wr_pay   (w_wr_pay)
    );

    befm_chip_hist #(
        .CHIP_COUNT (CHIP_COUNT),
        .CW         (CW)
    ) u_chip_hist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_idx   (r_idx),
        .o_last     (w_last),
        .i_wr_en    (w_commit && w_do_step),
        .i_wr_idx   (r_idx),
        .i_wr_bunch (r_bunch)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recv_ok <= 1'b0;
            r_idx     <= '0;
        end else if (w_accept) begin
            r_recv_ok <= w_recv_ok;
            r_idx     <= w_recv_ok ? w_idx[CW-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_chip  <= w_recv_ok ? befm_pkg::chip_of(w_idx) : '0;
            r_bunch <= w_recv_ok ? w_bunch : '0;
            r_kind  <= w_recv_ok ? w_kind : befm_pkg::RK_HITS;
            r_srch  <= w_srch;
            r_slot  <= w_slot;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            befm_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = befm_pkg::S_READ;
                end
            end
            befm_pkg::S_READ: begin
                n_state = befm_pkg::S_CALC;
            end
            befm_pkg::S_CALC: begin
                if (w_out_free) begin
                    n_state = befm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = befm_pkg::S_IDLE;
            end
        endcase
    end

    assign w_out_free = !r_out_valid || o_out.ready;

    always_comb begin
        w_in_ready = 1'b0;
        w_commit   = 1'b0;
        unique case (r_state)
            befm_pkg::S_IDLE: begin
                w_in_ready = 1'b1;
            end
            befm_pkg::S_READ: begin
            end
            befm_pkg::S_CALC: begin
                w_commit = w_out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= befm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // update
    assign w_cnt_inc   = (w_rd.count == befm_pkg::CNT_MAX) ? w_rd.count
                                                            : w_rd.count + befm_pkg::CNT_W'(1);
    assign w_do_step   = r_recv_ok && (r_srch.found || !r_srch.full);
    assign w_do_open   = w_do_step && !r_srch.found;
    assign w_do_close  = w_do_step && r_srch.found && (w_cnt_inc == {1'b0, r_enabled});
    assign w_do_update = w_do_step && r_srch.found && !w_do_close;
    assign w_rep       = r_recv_ok && (w_last == r_bunch);

    assign w_cmd.open   = w_commit && w_do_open;
    assign w_cmd.close  = w_commit && w_do_close;
    assign w_cmd.update = w_commit && w_do_update;

    assign w_wr_pay.count   = w_do_open ? befm_pkg::CNT_W'(1) : w_cnt_inc;
    assign w_wr_pay.trigger = w_do_open ? r_opened_cnt : w_rd.trigger;

    always_comb begin
        priority if (!r_recv_ok) begin
            w_status = befm_pkg::ST_BAD_RECV;
        end else if (!w_do_step) begin
            w_status = befm_pkg::ST_FULL;
        end else begin
            w_status = befm_pkg::ST_OK;
        end
    end

    always_comb begin
        priority if (!w_do_step) begin
            w_trig = '0;
        end else if (r_srch.found) begin
            w_trig = w_rd.trigger;
        end else begin
            w_trig = r_opened_cnt;
        end
    end

    always_comb begin
        priority if (w_do_open) begin
            n_total = w_total + TW'(1);
        end else if (w_do_close) begin
            n_total = w_total - TW'(1);
        end else begin
            n_total = w_total;
        end
    end

    assign n_closed_cnt = (w_do_close && (r_closed_cnt != befm_pkg::TRIG_MAX))
                          ? r_closed_cnt + XW'(1) : r_closed_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opened_cnt <= '0;
            r_closed_cnt <= '0;
        end else if (w_commit) begin
            if (w_do_open) begin
                r_opened_cnt <= r_opened_cnt + XW'(1);
            end
            r_closed_cnt <= n_closed_cnt;
        end
    end

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= befm_pkg::ENABLED_RST;
            r_target  <= befm_pkg::TARGET_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                befm_pkg::CFG_ENABLED: r_enabled <= i_cfg.data[befm_pkg::ENA_W-1:0];
                befm_pkg::CFG_TARGET:  r_target  <= i_cfg.data[XW-1:0];
                default: begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_o_status  <= w_status;
            r_o_chip    <= r_chip;
            r_o_trig    <= w_trig;
            r_o_kind    <= r_kind;
            r_o_bunch   <= r_bunch;
            r_o_opened  <= w_do_open;
            r_o_closed  <= w_do_close;
            r_o_rep     <= w_rep;
            r_o_several <= n_total > TW'(1);
            r_o_done    <= n_closed_cnt >= r_target;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_o_status;
    assign o_out.chip_id        = r_o_chip;
    assign o_out.trigger_number = r_o_trig;
    assign o_out.record_kind    = r_o_kind;
    assign o_out.bunch_out      = r_o_bunch;
    assign o_out.opened         = r_o_opened;
    assign o_out.closed         = r_o_closed;
    assign o_out.repeated       = r_o_rep;
    assign o_out.several_open   = r_o_several;
    assign o_out.run_done       = r_o_done;

    `BEFM_ASSERT(a_closed_monotonic, i_clk, i_rst_n, 1'b1 |=> r_closed_cnt >= $past(r_closed_cnt), "closed count went down")
    `BEFM_ASSERT(a_open_is_ok, i_clk, i_rst_n, (r_out_valid && r_o_opened) |-> (r_o_status == befm_pkg::ST_OK) && !r_o_closed, "open with bad status or close")
    `BEFM_ASSERT(a_accept_to_calc, i_clk, i_rst_n, w_accept |=> ##1 (r_state == befm_pkg::S_CALC), "update not reached two cycles after transfer")
    `BEFM_ASSERT(a_step_needs_recv, i_clk, i_rst_n, w_do_step |-> r_recv_ok, "table step for bad receiver")

endmodule

@@ dv/bunch_event_fragment_matcher_tb.sv @@
// Self-checking testbench for bunch_event_fragment_matcher: directed and random fragments,
// predicted event-building results checked field by field, random stalls on both channels.
// Depends on befm_pkg, the befm_if channel interfaces and the matcher RTL.
`timescale 1ns / 1ps

module bunch_event_fragment_matcher_tb;
    import befm_pkg::*;

    localparam int SLOTS = 8;
    localparam int CHIPS = 9;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [CHIP_W-1:0] CHIP_OF_RCV [CHIPS] =
        '{4'd8, 4'd7, 4'd6, 4'd0, 4'd5, 4'd1, 4'd4, 4'd2, 4'd3};

    typedef struct {
        logic [RECV_W-1:0] rcv;
        logic [7:0]        bval;
        logic              ok;
        logic              hits;
        logic              cons;
    } fragment_t;

    typedef struct packed {
        t_status              status;
        logic [CHIP_W-1:0]    chip;
        logic [TRIG_W-1:0]    trig;
        t_kind                kind;
        logic [BUNCH_W-1:0]   bunch;
        logic                 opened;
        logic                 closed;
        logic                 repeated;
        logic                 several;
        logic                 done;
    } event_record_t;

    logic i_clk;
    logic i_rst_n;

    befm_in_if  frag_if ();
    befm_out_if rec_if ();
    befm_cfg_if cfg_if ();

    bunch_event_fragment_matcher #(
        .OPEN_SLOTS(SLOTS),
        .CHIP_COUNT(CHIPS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (frag_if),
        .o_out  (rec_if),
        .i_cfg  (cfg_if)
    );

    // event builder state as seen by the checker
    logic [BUNCH_W-1:0] slot_bunch [SLOTS];
    logic [CNT_W-1:0]   slot_cnt [SLOTS];
    logic [TRIG_W-1:0]  slot_trig [SLOTS];
    int                 slot_total;
    logic [BUNCH_W-1:0] chip_last [CHIPS];
    logic [TRIG_W-1:0]  opened_trigs;
    logic [TRIG_W-1:0]  closed_trigs;
    logic [ENA_W-1:0]   enabled_cfg;
    logic [TRIG_W-1:0]  target_cfg;

    fragment_t     pending_frags [$];
    event_record_t expected_records [$];

    int items_queued;
    int records_seen;
    int errors;
    int unsigned cycle_count;

    bit frag_taken;
    int frag_wait;
    int frag_mode;
    bit rec_taken;
    int rec_wait;
    int rec_mode;
    int stall_left;
    int stall_count;

    // live events used by the random generator
    int ev_bunch [3];
    int ev_list [3][CHIPS];
    int ev_pos [3];
    int ev_len [3];

    function automatic event_record_t match_fragment(input logic [RECV_W-1:0] rcv,
                                                     input logic [7:0] bval,
                                                     input logic ok, input logic hits,
                                                     input logic cons);
        event_record_t r;
        logic [BUNCH_W-1:0] b;
        int idx;
        int pos;
        int i;
        bit found;
        r = '0;
        r.status = ST_OK;
        r.kind = RK_HITS;
        if (rcv == 0 || rcv > CHIPS) begin
            r.status = ST_BAD_RECV;
        end else begin
            idx = rcv - 1;
            r.chip = CHIP_OF_RCV[idx];
            b = ok ? {1'b0, bval} : FAIL_BUNCH;
            r.bunch = b;
            if (!ok || (hits && !cons)) begin
                r.kind = RK_ERROR;
            end else if (!hits) begin
                r.kind = RK_EMPTY;
            end
            r.repeated = (chip_last[idx] == b);
            found = 1'b0;
            pos = 0;
            for (i = 0; i < slot_total; i++) begin
                if (!found && slot_bunch[i] == b) begin
                    found = 1'b1;
                    pos = i;
                end
            end
            if (!found && slot_total >= SLOTS) begin
                r.status = ST_FULL;
            end else begin
                if (!found) begin
                    slot_bunch[slot_total] = b;
                    slot_cnt[slot_total] = 5'd1;
                    slot_trig[slot_total] = opened_trigs;
                    slot_total++;
                    r.trig = opened_trigs;
                    opened_trigs = opened_trigs + 1;
                    r.opened = 1'b1;
                end else begin
                    if (slot_cnt[pos] != CNT_MAX) slot_cnt[pos] = slot_cnt[pos] + CNT_W'(1);
                    r.trig = slot_trig[pos];
                    if (slot_cnt[pos] == CNT_W'(enabled_cfg)) begin
                        for (i = pos; i < slot_total - 1; i++) begin
                            slot_bunch[i] = slot_bunch[i + 1];
                            slot_cnt[i] = slot_cnt[i + 1];
                            slot_trig[i] = slot_trig[i + 1];
                        end
                        slot_total--;
                        if (closed_trigs != TRIG_MAX) closed_trigs = closed_trigs + 1;
                        r.closed = 1'b1;
                    end
                end
                chip_last[idx] = b;
            end
        end
        r.several = (slot_total > 1);
        r.done = (closed_trigs >= target_cfg);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endfunction

    function automatic int draw_gap(input int mode);
        int g;
        case (mode)
            0: g = 0;
            1: g = $urandom_range(0, 3);
            default: g = $urandom_range(0, 16);
        endcase
        return g;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d of %0d records seen", $time, records_seen, items_queued);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // fragment channel: accept at the rising edge, drive at the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && frag_if.valid && frag_if.ready) begin
            expected_records.insert(expected_records.size(),
                match_fragment(frag_if.receiver, frag_if.bunch_value,
                frag_if.decode_ok, frag_if.has_hits, frag_if.hits_consistent));
            frag_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        fragment_t nxt;
        logic nv;
        if (i_rst_n) begin
            nv = frag_if.valid;
            if (frag_taken) begin
                frag_taken = 1'b0;
                nv = 1'b0;
            end
            if (!nv) begin
                if (frag_wait > 0) begin
                    frag_wait--;
                end else if (pending_frags.size() > 0) begin
                    nxt = pending_frags.pop_front();
                    frag_if.receiver <= nxt.rcv;
                    frag_if.bunch_value <= nxt.bval;
                    frag_if.decode_ok <= nxt.ok;
                    frag_if.has_hits <= nxt.hits;
                    frag_if.hits_consistent <= nxt.cons;
                    nv = 1'b1;
                    frag_wait = draw_gap(frag_mode);
                    if ($urandom_range(0, 40) == 0) frag_mode = $urandom_range(0, 2);
                end
            end
            frag_if.valid <= nv;
        end
    end

    // result channel
    always @(posedge i_clk) begin
        event_record_t act;
        event_record_t exp_r;
        if (i_rst_n && rec_if.valid && rec_if.ready) begin
            act.status = t_status'(rec_if.status);
            act.chip = rec_if.chip_id;
            act.trig = rec_if.trigger_number;
            act.kind = t_kind'(rec_if.record_kind);
            act.bunch = rec_if.bunch_out;
            act.opened = rec_if.opened;
            act.closed = rec_if.closed;
            act.repeated = rec_if.repeated;
            act.several = rec_if.several_open;
            act.done = rec_if.run_done;
            if (expected_records.size() == 0) begin
                errors++;
                $display("%0t: record with none expected: expected nothing, actual %p",
                         $time, act);
            end else begin
                exp_r = expected_records.pop_front();
                check_field("status", exp_r.status, act.status);
                check_field("chip_id", exp_r.chip, act.chip);
                check_field("trigger_number", exp_r.trig, act.trig);
                check_field("record_kind", exp_r.kind, act.kind);
                check_field("bunch_out", exp_r.bunch, act.bunch);
                check_field("opened", exp_r.opened, act.opened);
                check_field("closed", exp_r.closed, act.closed);
                check_field("repeated", exp_r.repeated, act.repeated);
                check_field("several_open", exp_r.several, act.several);
                check_field("run_done", exp_r.done, act.done);
            end
            records_seen++;
            rec_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (rec_taken) begin
                rec_taken = 1'b0;
                rec_wait = draw_gap(rec_mode);
                if ($urandom_range(0, 40) == 0) rec_mode = $urandom_range(0, 2);
                // long hold-off so the matcher backs up into the fragment channel
                if (stall_count < 2 && records_seen >= 300 + 700 * stall_count &&
                    pending_frags.size() > 16) begin
                    stall_left = 400;
                    stall_count++;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                rec_if.ready <= 1'b0;
            end else if (rec_wait > 0) begin
                rec_wait--;
                rec_if.ready <= 1'b0;
            end else begin
                rec_if.ready <= 1'b1;
            end
        end
    end

    task automatic push_frag(input logic [RECV_W-1:0] rcv, input logic [7:0] bval,
                             input logic ok, input logic hits, input logic cons);
        fragment_t f;
        f.rcv = rcv;
        f.bval = bval;
        f.ok = ok;
        f.hits = hits;
        f.cons = cons;
        pending_frags.insert(pending_frags.size(), f);
        items_queued++;
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [31:0] val);
        @(negedge i_clk);
        cfg_if.index <= idx;
        cfg_if.data <= val;
        cfg_if.valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            CFG_ENABLED: enabled_cfg = val[ENA_W-1:0];
            CFG_TARGET:  target_cfg = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (records_seen != items_queued) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic start_event(input int s);
        int i;
        int j;
        int tmp;
        for (i = 0; i < CHIPS; i++) ev_list[s][i] = i + 1;
        for (i = CHIPS - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = ev_list[s][i];
            ev_list[s][i] = ev_list[s][j];
            ev_list[s][j] = tmp;
        end
        ev_bunch[s] = $urandom_range(0, 255);
        ev_pos[s] = 0;
        ev_len[s] = int'(enabled_cfg);
    endtask

    // feed every open bunch the fragments it still lacks, so the next phase starts empty
    task automatic close_open_bunches();
        int i;
        int j;
        int need;
        for (i = 0; i < slot_total; i++) begin
            need = (int'(slot_cnt[i]) < int'(enabled_cfg)) ?
                   int'(enabled_cfg) - int'(slot_cnt[i]) : 0;
            for (j = 0; j < need; j++) begin
                if (slot_bunch[i] == FAIL_BUNCH) begin
                    push_frag(RECV_W'($urandom_range(1, CHIPS)), 8'($urandom_range(0, 255)),
                              1'b0, 1'($urandom_range(0, 1)), 1'b1);
                end else begin
                    push_frag(RECV_W'($urandom_range(1, CHIPS)), slot_bunch[i][7:0], 1'b1,
                              1'($urandom_range(0, 1)), 1'b1);
                end
            end
        end
        wait_idle();
    endtask

    task automatic gen_random(input int n);
        int k;
        int r;
        int s;
        int b;
        for (s = 0; s < 3; s++) start_event(s);
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            s = $urandom_range(0, 2);
            if (r < 70) begin
                if (ev_pos[s] >= ev_len[s]) start_event(s);
                push_frag(RECV_W'(ev_list[s][ev_pos[s]]), 8'(ev_bunch[s]), 1'b1,
                          1'($urandom_range(0, 1)), $urandom_range(0, 9) != 0);
                ev_pos[s]++;
            end else if (r < 78) begin
                b = $urandom_range(CHIPS, 15);
                push_frag(RECV_W'((b == CHIPS) ? 0 : b), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end else if (r < 84) begin
                push_frag(RECV_W'($urandom_range(1, CHIPS)), 8'($urandom_range(0, 255)), 1'b0,
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (r < 90) begin
                push_frag(RECV_W'($urandom_range(1, CHIPS)), 8'($urandom_range(0, 255)), 1'b1,
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                push_frag(RECV_W'($urandom_range(1, CHIPS)), 8'(ev_bunch[s]), 1'b1,
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic run_phase(input int en, input logic [31:0] target, input int n);
        int k;
        write_reg(CFG_ENABLED, en);
        write_reg(CFG_TARGET, target);
        if (en == 1) begin
            // one bunch hit far past the count limit
            for (k = 0; k < 40; k++) begin
                push_frag(RECV_W'($urandom_range(1, CHIPS)), 8'd77, 1'b1,
                          1'($urandom_range(0, 1)), 1'b1);
            end
        end
        gen_random(n);
        wait_idle();
        close_open_bunches();
    endtask

    initial begin
        int i;
        i_rst_n = 1'b0;
        frag_if.valid = 1'b0;
        frag_if.receiver = '0;
        frag_if.bunch_value = '0;
        frag_if.decode_ok = 1'b0;
        frag_if.has_hits = 1'b0;
        frag_if.hits_consistent = 1'b0;
        rec_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_ENABLED;
        cfg_if.data = '0;
        frag_mode = 2;
        rec_mode = 2;
        for (i = 0; i < SLOTS; i++) begin
            slot_bunch[i] = '0;
            slot_cnt[i] = '0;
            slot_trig[i] = '0;
        end
        for (i = 0; i < CHIPS; i++) chip_last[i] = NONE_BUNCH;
        slot_total = 0;
        opened_trigs = '0;
        closed_trigs = '0;
        enabled_cfg = ENABLED_RST;
        target_cfg = TARGET_RST;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // bad receivers, every record kind, eight open bunches, full table, repeats
        push_frag(4'd0, 8'd5, 1'b1, 1'b1, 1'b1);
        push_frag(4'd15, 8'hFF, 1'b1, 1'b0, 1'b0);
        push_frag(4'd10, 8'd0, 1'b0, 1'b1, 1'b0);
        push_frag(4'd1, 8'd0, 1'b1, 1'b1, 1'b1);
        push_frag(4'd2, 8'd255, 1'b1, 1'b0, 1'b1);
        push_frag(4'd3, 8'hAA, 1'b0, 1'b1, 1'b1);
        push_frag(4'd4, 8'd10, 1'b1, 1'b1, 1'b0);
        push_frag(4'd5, 8'd11, 1'b1, 1'b0, 1'b0);
        push_frag(4'd6, 8'd12, 1'b1, 1'b1, 1'b1);
        push_frag(4'd7, 8'd13, 1'b1, 1'b1, 1'b1);
        push_frag(4'd8, 8'd14, 1'b1, 1'b0, 1'b1);
        push_frag(4'd9, 8'd15, 1'b1, 1'b1, 1'b1);
        push_frag(4'd9, 8'd15, 1'b1, 1'b1, 1'b1);
        push_frag(4'd1, 8'd0, 1'b1, 1'b0, 1'b1);
        push_frag(4'd9, 8'h55, 1'b0, 1'b0, 1'b0);
        push_frag(4'd3, 8'h00, 1'b0, 1'b1, 1'b0);
        push_frag(4'd2, 8'd255, 1'b1, 1'b1, 1'b0);
        push_frag(4'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        wait_idle();
        close_open_bunches();

        run_phase(9, 32'hFFFF_FFFF, 180);
        run_phase(3, closed_trigs + 10, 160);
        run_phase(5, 32'd1, 160);
        run_phase(2, closed_trigs + 30, 160);
        run_phase(7, $urandom, 160);
        run_phase(4, closed_trigs + 15, 160);
        run_phase(9, closed_trigs + 5, 160);
        run_phase(1, 32'hFFFF_FFFF, 160);

        repeat (20) @(negedge i_clk);
        if (expected_records.size() != 0) begin
            errors++;
            $display("%0t: records missing: expected %0d more, actual 0", $time,
                     expected_records.size());
        end
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
